@@ design/cgrt_pkg.sv @@
// Shared constants and types of the character grid rotate/transpose block.
package cgrt_pkg;

  localparam int MAX_SIDE_DEF = 32;
  localparam int JOBQ_DEPTH   = 2;

  localparam logic [7:0] CH_NL  = 8'd10;
  localparam logic [7:0] CH_BAR = 8'd124;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_FETCH = 1'b1;

  localparam logic [1:0] MODE_REFLECT  = 2'd0;
  localparam logic [1:0] MODE_ROTATE   = 2'd1;
  localparam logic [1:0] MODE_COMBINED = 2'd2;

  localparam logic [1:0] KIND_ROW  = 2'd0;
  localparam logic [1:0] KIND_REFL = 2'd1;
  localparam logic [1:0] KIND_ROT  = 2'd2;

  typedef struct packed {
    logic       is_write;
    logic       use_ram;
    logic       last;
    logic       empty_res;
    logic       overflow;
    logic [7:0] data;
  } job_ctl_t;

endpackage

@@ design/cgrt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module cgrt_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic          re,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data
);

  logic [W-1:0] mem_r [DEPTH];
  logic [W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/cgrt_jobq.sv @@
// Short job queue between the front and the back of the block.
module cgrt_jobq #(
  parameter int AW = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  cgrt_pkg::job_ctl_t wr_ctl,
  input  logic [AW-1:0]     wr_addr,
  output logic              q_full,
  input  logic              rd_en,
  output cgrt_pkg::job_ctl_t rd_ctl,
  output logic [AW-1:0]     rd_addr,
  output logic              q_empty
);
  import cgrt_pkg::*;

  localparam int PW = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;
  localparam int NW = $clog2(JOBQ_DEPTH + 1);

  job_ctl_t      ctl_r  [JOBQ_DEPTH];
  logic [AW-1:0] addr_r [JOBQ_DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (wr_en) begin
      wp_nxt = (wp_r == PW'(JOBQ_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (rd_en) begin
      rp_nxt = (rp_r == PW'(JOBQ_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ctl_r[wp_r]  <= wr_ctl;
      addr_r[wp_r] <= wr_addr;
    end
  end

  assign rd_ctl  = ctl_r[rp_r];
  assign rd_addr = addr_r[rp_r];
  assign q_full  = (cnt_r == NW'(JOBQ_DEPTH));
  assign q_empty = (cnt_r == '0);

endmodule

@@ design/cgrt_front.sv @@
// Front end: accepts transactions, tracks load and readout state, issues jobs.
module cgrt_front #(
  parameter int MAX_SIDE = cgrt_pkg::MAX_SIDE_DEF,
  localparam int CW      = $clog2(MAX_SIDE + 1),
  localparam int DEPTH   = MAX_SIDE * MAX_SIDE,
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic               in_func,
  input  logic [7:0]         in_char_in,
  input  logic [1:0]         mode,
  output logic               job_valid,
  output cgrt_pkg::job_ctl_t job_ctl,
  output logic [AW-1:0]      job_addr
);
  import cgrt_pkg::*;

  logic [CW-1:0] rc_r, rc_nxt, side_r, side_nxt, lc_r, lc_nxt;
  logic [CW-1:0] line_r, line_nxt, pos_r, pos_nxt;
  logic [1:0]    seg_r, seg_nxt;
  logic          drain_r, drain_nxt, ovf_r, ovf_nxt;

  logic [CW-1:0] n, line, pos, colsel, r_sel, c_sel;
  logic [1:0]    seg, nseg_m1, kind;
  logic          lastseg, is_last;

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] r,
                                              input logic [CW-1:0] c);
    return AW'(AW'(r) * AW'(MAX_SIDE)) + AW'(c);
  endfunction

  always_comb begin
    rc_nxt    = rc_r;
    side_nxt  = side_r;
    lc_nxt    = lc_r;
    line_nxt  = line_r;
    pos_nxt   = pos_r;
    seg_nxt   = seg_r;
    drain_nxt = drain_r;
    ovf_nxt   = ovf_r;
    job_valid = 1'b0;
    job_ctl   = '0;
    job_addr  = '0;
    n         = '0;
    line      = '0;
    pos       = '0;
    colsel    = '0;
    r_sel     = '0;
    c_sel     = '0;
    seg       = '0;
    nseg_m1   = '0;
    kind      = KIND_REFL;
    lastseg   = 1'b0;
    is_last   = 1'b0;
    if (accept) begin
      if (in_func == FUNC_LOAD) begin
        if (!drain_r) begin
          if (in_char_in == CH_NL) begin
            if (rc_r < CW'(MAX_SIDE)) begin
              if (rc_r == '0) begin
                side_nxt = lc_r;
              end
              rc_nxt = rc_r + 1'b1;
            end
            lc_nxt = '0;
          end else if (rc_r >= CW'(MAX_SIDE) || lc_r >= CW'(MAX_SIDE)) begin
            ovf_nxt = 1'b1;
          end else begin
            job_valid        = 1'b1;
            job_ctl.is_write = 1'b1;
            job_ctl.data     = in_char_in;
            job_addr         = cell_addr(rc_r, lc_r);
            lc_nxt           = lc_r + 1'b1;
          end
        end
      end else begin
        job_valid        = 1'b1;
        job_ctl.overflow = ovf_r;
        if (!drain_r) begin
          if (lc_r != '0) begin
            if (rc_r < CW'(MAX_SIDE)) begin
              if (rc_r == '0) begin
                side_nxt = lc_r;
              end
              rc_nxt = rc_r + 1'b1;
            end
            lc_nxt = '0;
          end
          if (side_nxt == '0) begin
            job_ctl.empty_res = 1'b1;
            rc_nxt   = '0;
            side_nxt = '0;
            lc_nxt   = '0;
            ovf_nxt  = 1'b0;
          end else begin
            drain_nxt = 1'b1;
            line_nxt  = '0;
            seg_nxt   = '0;
            pos_nxt   = '0;
          end
        end
        if (drain_nxt) begin
          n       = side_nxt;
          line    = line_nxt;
          pos     = pos_nxt;
          nseg_m1 = (mode == MODE_COMBINED) ? 2'd2 : 2'd0;
          seg     = (seg_nxt > nseg_m1) ? nseg_m1 : seg_nxt;
          lastseg = (seg == nseg_m1);
          case (mode)
            MODE_COMBINED: kind = seg;
            MODE_ROTATE:   kind = KIND_ROT;
            default:       kind = KIND_REFL;
          endcase
          if (pos >= n) begin
            if (!lastseg) begin
              job_ctl.data = CH_BAR;
              seg_nxt      = seg + 1'b1;
            end else begin
              job_ctl.data = CH_NL;
              line_nxt     = (line >= CW'(MAX_SIDE)) ? line : line + 1'b1;
              seg_nxt      = '0;
            end
            pos_nxt = '0;
          end else begin
            colsel = (line >= n) ? '0 : n - 1'b1 - line;
            case (kind)
              KIND_ROW: begin
                r_sel = line;
                c_sel = pos;
              end
              KIND_REFL: begin
                r_sel = n - 1'b1 - pos;
                c_sel = colsel;
              end
              default: begin
                r_sel = pos;
                c_sel = colsel;
              end
            endcase
            // Rows past the end of the store read as zero.
            job_ctl.use_ram = (r_sel < CW'(MAX_SIDE));
            job_addr        = cell_addr(r_sel, c_sel);
            is_last         = (line >= n - 1'b1) && lastseg && ((pos + 1'b1) == n);
            job_ctl.last    = is_last;
            pos_nxt         = pos + 1'b1;
            if (is_last) begin
              rc_nxt    = '0;
              side_nxt  = '0;
              lc_nxt    = '0;
              drain_nxt = 1'b0;
              line_nxt  = '0;
              seg_nxt   = '0;
              pos_nxt   = '0;
              ovf_nxt   = 1'b0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_r    <= '0;
      side_r  <= '0;
      lc_r    <= '0;
      line_r  <= '0;
      pos_r   <= '0;
      seg_r   <= '0;
      drain_r <= 1'b0;
      ovf_r   <= 1'b0;
    end else begin
      rc_r    <= rc_nxt;
      side_r  <= side_nxt;
      lc_r    <= lc_nxt;
      line_r  <= line_nxt;
      pos_r   <= pos_nxt;
      seg_r   <= seg_nxt;
      drain_r <= drain_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

@@ design/cgrt_back.sv @@
// Back end: executes queued jobs against the grid memory and holds results.
module cgrt_back #(
  parameter int MAX_SIDE = cgrt_pkg::MAX_SIDE_DEF,
  localparam int DEPTH   = MAX_SIDE * MAX_SIDE,
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  cgrt_pkg::job_ctl_t q_ctl,
  input  logic [AW-1:0]      q_addr,
  output logic               q_pop,
  output logic               res_valid,
  input  logic               res_pop,
  output logic [7:0]         res_char,
  output logic               res_last,
  output logic               res_empty,
  output logic               res_ovf
);
  import cgrt_pkg::*;

  logic       s1_valid_r, s1_valid_nxt;
  job_ctl_t   s1_ctl_r;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_char_r;
  logic       out_last_r, out_empty_r, out_ovf_r;
  logic [7:0] rd_data;
  logic       s1_move, take_fetch;

  assign s1_move    = s1_valid_r && (!out_valid_r || res_pop);
  assign q_pop      = !q_empty && (q_ctl.is_write || !s1_valid_r || s1_move);
  assign take_fetch = q_pop && !q_ctl.is_write;

  cgrt_ram #(
    .W     (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (q_pop && q_ctl.is_write),
    .wr_addr (q_addr),
    .wr_data (q_ctl.data),
    .re      (take_fetch && q_ctl.use_ram),
    .rd_addr (q_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (take_fetch) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (res_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take_fetch) begin
      s1_ctl_r <= q_ctl;
    end
    if (s1_move) begin
      out_char_r  <= s1_ctl_r.use_ram ? rd_data : s1_ctl_r.data;
      out_last_r  <= s1_ctl_r.last;
      out_empty_r <= s1_ctl_r.empty_res;
      out_ovf_r   <= s1_ctl_r.overflow;
    end
  end

  assign res_valid = out_valid_r;
  assign res_char  = out_char_r;
  assign res_last  = out_last_r;
  assign res_empty = out_empty_r;
  assign res_ovf   = out_ovf_r;

endmodule

@@ design/char_grid_rotate_transpose.sv @@
// Top level of the character grid reflect/rotate engine.
// Load transactions (in_func 0) write one grid byte each and fetch transactions
// (in_func 1) return one output byte each. Both kinds are accepted one per cycle
// while the two-entry job queue has room; a fetch result passes through the job
// queue, the registered read of the grid memory and the result register before it
// reaches the output. Sustained throughput is one transaction per cycle as long as
// results are popped; full rises only when the job queue backs up behind results.
module char_grid_rotate_transpose #(
  parameter int MAX_SIDE = cgrt_pkg::MAX_SIDE_DEF,
  localparam int DEPTH   = MAX_SIDE * MAX_SIDE,
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic       in_func,
  input  logic [7:0] in_char_in,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char_out,
  output logic       out_last,
  output logic       out_empty_res,
  output logic       out_overflow,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_mode
);
  import cgrt_pkg::*;

  logic [1:0]    mode_r;
  logic          accept;
  logic          job_valid;
  job_ctl_t      job_ctl;
  logic [AW-1:0] job_addr;
  logic          jq_full, jq_empty, jq_pop;
  job_ctl_t      jq_ctl;
  logic [AW-1:0] jq_addr;
  logic          res_valid;

  assign cfg_ready = 1'b1;
  assign accept    = push && !jq_full;
  assign full      = jq_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_REFLECT;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_mode;
    end
  end

  cgrt_front #(.MAX_SIDE(MAX_SIDE)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .in_func    (in_func),
    .in_char_in (in_char_in),
    .mode       (mode_r),
    .job_valid  (job_valid),
    .job_ctl    (job_ctl),
    .job_addr   (job_addr)
  );

  cgrt_jobq #(.AW(AW)) u_jobq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (job_valid),
    .wr_ctl  (job_ctl),
    .wr_addr (job_addr),
    .q_full  (jq_full),
    .rd_en   (jq_pop),
    .rd_ctl  (jq_ctl),
    .rd_addr (jq_addr),
    .q_empty (jq_empty)
  );

  cgrt_back #(.MAX_SIDE(MAX_SIDE)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (jq_empty),
    .q_ctl     (jq_ctl),
    .q_addr    (jq_addr),
    .q_pop     (jq_pop),
    .res_valid (res_valid),
    .res_pop   (pop),
    .res_char  (out_char_out),
    .res_last  (out_last),
    .res_empty (out_empty_res),
    .res_ovf   (out_overflow)
  );

  assign empty = !res_valid;

  a_no_job_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid |-> !jq_full)
    else $error("Job issued while the job queue is full.");

  a_empty_result_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_empty_res) |-> (!out_last && out_char_out == 8'd0))
    else $error("Empty-grid result carries data or a last flag.");

  a_pop_only_valid_job: assert property (@(posedge clk) disable iff (!rst_n)
    jq_pop |-> !jq_empty)
    else $error("Back end popped an empty job queue.");

endmodule

@@ test/grid_text_checker.sv @@
// Checker that predicts and compares the output bytes of the character grid engine.
module grid_text_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  logic       full,
  input  logic       in_func,
  input  logic [7:0] in_char_in,
  input  logic       empty,
  input  logic       pop,
  input  logic [7:0] out_char_out,
  input  logic       out_last,
  input  logic       out_empty_res,
  input  logic       out_overflow,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [1:0] cfg_mode,
  output int         outstanding,
  output int         fail_count,
  output int         bytes_checked
);
  import cgrt_pkg::*;

  localparam int SIDE_MAX = MAX_SIDE_DEF;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       empty_res;
    logic       overflow;
  } text_byte_t;

  logic [7:0] g_cells [0:SIDE_MAX*SIDE_MAX-1];
  logic [5:0] rows_in, side_n, col_in, line_k, pos_k;
  logic [1:0] seg_k, cur_mode;
  logic       reading, trunc_flag;
  text_byte_t byte_q[$];
  int         mismatches = 0;
  int         checked = 0;

  task automatic clear_text();
    rows_in    = '0;
    side_n     = '0;
    col_in     = '0;
    reading    = 1'b0;
    line_k     = '0;
    seg_k      = '0;
    pos_k      = '0;
    trunc_flag = 1'b0;
  endtask

  task automatic end_row();
    if (rows_in < SIDE_MAX) begin
      if (rows_in == 0) begin
        side_n = col_in;
      end
      rows_in = rows_in + 1'b1;
    end
    col_in = '0;
  endtask

  function automatic logic [7:0] cell_at(input int r, input int c);
    if (r >= SIDE_MAX || c >= SIDE_MAX) begin
      return 8'd0;
    end
    return g_cells[r * SIDE_MAX + c];
  endfunction

  task automatic take_load(input logic [7:0] c);
    if (reading) begin
      return;
    end
    if (c == CH_NL) begin
      end_row();
      return;
    end
    if (rows_in >= SIDE_MAX || col_in >= SIDE_MAX) begin
      trunc_flag = 1'b1;
      return;
    end
    g_cells[int'(rows_in) * SIDE_MAX + int'(col_in)] = c;
    col_in = col_in + 1'b1;
  endtask

  task automatic take_fetch(output text_byte_t b);
    int         n, nseg, seg, colsel;
    logic [1:0] kind;
    logic       lastseg;
    b = '0;
    if (!reading) begin
      if (col_in > 0) begin
        end_row();
      end
      if (side_n == 0) begin
        b.empty_res = 1'b1;
        b.overflow  = trunc_flag;
        clear_text();
        return;
      end
      reading = 1'b1;
      line_k  = '0;
      seg_k   = '0;
      pos_k   = '0;
    end
    n       = side_n;
    nseg    = (cur_mode == MODE_COMBINED) ? 3 : 1;
    seg     = (seg_k >= nseg) ? nseg - 1 : seg_k;
    lastseg = (seg == nseg - 1);
    if (cur_mode == MODE_COMBINED) begin
      kind = 2'(seg);
    end else if (cur_mode == MODE_ROTATE) begin
      kind = KIND_ROT;
    end else begin
      kind = KIND_REFL;
    end
    if (pos_k >= n) begin
      if (!lastseg) begin
        b.ch  = CH_BAR;
        seg_k = 2'(seg + 1);
      end else begin
        b.ch = CH_NL;
        // Every line number at or past the side limit behaves the same.
        if (line_k < SIDE_MAX) begin
          line_k = line_k + 1'b1;
        end
        seg_k = '0;
      end
      pos_k = '0;
    end else begin
      colsel = (line_k >= n) ? 0 : n - 1 - line_k;
      case (kind)
        KIND_ROW:  b.ch = cell_at(line_k, pos_k);
        KIND_REFL: b.ch = cell_at(n - 1 - pos_k, colsel);
        default:   b.ch = cell_at(pos_k, colsel);
      endcase
      b.last = (line_k + 1 >= n) && lastseg && (pos_k + 1 == n);
      pos_k  = pos_k + 1'b1;
    end
    b.overflow = trunc_flag;
    if (b.last) begin
      clear_text();
    end
  endtask

  task automatic compare_field(input string field, input logic [7:0] expected_v,
                               input logic [7:0] actual_v);
    if (actual_v !== expected_v) begin
      mismatches++;
      $error("%s mismatch: expected %0d, actual %0d", field, expected_v, actual_v);
    end
  endtask

  always @(posedge clk) begin : watch
    text_byte_t want;
    if (!rst_n) begin
      clear_text();
      cur_mode = MODE_REFLECT;
      byte_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        cur_mode = cfg_mode;
      end
      if (pop && !empty) begin
        if (byte_q.size() == 0) begin
          mismatches++;
          $error("result transaction with no expected byte waiting: char_out %0d",
                 out_char_out);
        end else begin
          want = byte_q.pop_front();
          compare_field("char_out", want.ch, out_char_out);
          compare_field("last", 8'(want.last), 8'(out_last));
          compare_field("empty_res", 8'(want.empty_res), 8'(out_empty_res));
          compare_field("overflow", 8'(want.overflow), 8'(out_overflow));
          checked++;
        end
      end
      if (push && !full) begin
        if (in_func == FUNC_FETCH) begin
          take_fetch(want);
          byte_q.insert(byte_q.size(), want);
        end else begin
          take_load(in_char_in);
        end
      end
    end
    outstanding   <= byte_q.size();
    fail_count    <= mismatches;
    bytes_checked <= checked;
  end

endmodule

@@ test/testbench.sv @@
// Top of the testbench: stimulus, receiver stalls and verdict for the grid engine.
module testbench;
  import cgrt_pkg::*;

  localparam logic [1:0] MODE_SPARE   = 2'd3;
  localparam int         RANDOM_ITEMS = 480;
  localparam int         WIDE_FETCHES = 66;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         CYCLE_LIMIT  = 600000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       push = 1'b0;
  logic       in_func = FUNC_LOAD;
  logic [7:0] in_char_in = 8'd0;
  logic       pop = 1'b0;
  logic       cfg_valid = 1'b0;
  logic [1:0] cfg_mode = MODE_REFLECT;
  logic       full, empty, cfg_ready;
  logic [7:0] out_char_out;
  logic       out_last, out_empty_res, out_overflow;

  int outstanding, fail_count, bytes_checked;
  int loads_sent = 0;
  int fetches_sent = 0;
  int ignored_loads = 0;
  int grids_done = 0;
  int empties = 0;
  int mode_writes = 0;
  int burst_left = 0;
  int hold_count = 0;
  int cycle_count = 0;
  bit gaps_on = 1'b1;
  bit holding = 1'b0;
  logic [1:0] mode_now = MODE_REFLECT;

  bit         stored [0:31][0:31];
  int         row_len[$];
  logic [7:0] fixed_chars[$];

  char_grid_rotate_transpose dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_func      (in_func),
    .in_char_in   (in_char_in),
    .empty        (empty),
    .pop          (pop),
    .out_char_out (out_char_out),
    .out_last     (out_last),
    .out_empty_res(out_empty_res),
    .out_overflow (out_overflow),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_mode     (cfg_mode)
  );

  grid_text_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_func      (in_func),
    .in_char_in   (in_char_in),
    .empty        (empty),
    .pop          (pop),
    .out_char_out (out_char_out),
    .out_last     (out_last),
    .out_empty_res(out_empty_res),
    .out_overflow (out_overflow),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_mode     (cfg_mode),
    .outstanding  (outstanding),
    .fail_count   (fail_count),
    .bytes_checked(bytes_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : receiver
    int run_len, stall_len, holds_seen;
    holds_seen = 0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if (holds_seen != hold_count) begin
        holds_seen = hold_count;
        pop <= 1'b0;
        holding = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding = 1'b0;
      end else begin
        run_len   = $urandom_range(1, 24);
        stall_len = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 5) : 0;
        pop <= 1'b1;
        repeat (run_len) @(posedge clk);
        if (stall_len != 0) begin
          pop <= 1'b0;
          repeat (stall_len) @(posedge clk);
        end
      end
    end
  end

  function automatic logic [7:0] next_char();
    logic [7:0] c;
    if (fixed_chars.size() != 0) begin
      return fixed_chars.pop_front();
    end
    do begin
      c = 8'($urandom_range(0, 255));
    end while (c == CH_NL);
    return c;
  endfunction

  task automatic send_item(input logic f, input logic [7:0] c);
    if (gaps_on && burst_left <= 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    push       <= 1'b1;
    in_func    <= f;
    in_char_in <= c;
    @(posedge clk);
    while (full) @(posedge clk);
    burst_left--;
    if (f == FUNC_FETCH) begin
      fetches_sent++;
    end else begin
      loads_sent++;
    end
  endtask

  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_mode(input logic [1:0] m);
    settle();
    cfg_valid <= 1'b1;
    cfg_mode  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    mode_now = m;
    mode_writes++;
  endtask

  task automatic fetch_n(input int count, input bit junk);
    for (int i = 0; i < count; i++) begin
      if (junk && i > 0 && $urandom_range(0, 5) == 0) begin
        send_item(FUNC_LOAD, 8'($urandom_range(0, 255)));
        ignored_loads++;
      end
      send_item(FUNC_FETCH, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic read_out(input int side, input bit junk);
    int count;
    if (side == 0) begin
      count = 1;
      empties++;
    end else if (mode_now == MODE_COMBINED) begin
      count = side * (3 * side + 2) + side - 1;
    end else begin
      count = side * side + side - 1;
    end
    grids_done++;
    fetch_n(count, junk);
  endtask

  task automatic load_text(input bit trail_nl);
    for (int r = 0; r < row_len.size(); r++) begin
      for (int c = 0; c < row_len[r]; c++) begin
        send_item(FUNC_LOAD, next_char());
        if (r < 32 && c < 32) begin
          stored[r][c] = 1'b1;
        end
      end
      if (r + 1 < row_len.size() || trail_nl) begin
        send_item(FUNC_LOAD, CH_NL);
      end
    end
  endtask

  // Short or missing rows are only kept where every cell shown was written before.
  task automatic fix_rows(input int side);
    int  have;
    bit  covered;
    for (int r = 0; r < side; r++) begin
      have    = (r < row_len.size()) ? row_len[r] : 0;
      covered = 1'b1;
      for (int c = have; c < side; c++) begin
        if (!stored[r][c]) begin
          covered = 1'b0;
        end
      end
      if (!covered) begin
        while (row_len.size() <= r) row_len.insert(row_len.size(), 0);
        row_len[r] = side;
      end
    end
  endtask

  task automatic make_grid(input bit plain_only);
    int side, flavor, nrows;
    if (plain_only) begin
      side = $urandom_range(3, 6);
    end else begin
      side = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
    end
    flavor = plain_only ? 0 : $urandom_range(0, 9);
    row_len.delete();
    case (flavor)
      5: begin
        repeat (side) row_len.insert(row_len.size(), side);
        for (int r = 1; r < side; r++) begin
          if ($urandom_range(0, 1) == 1) begin
            row_len[r] = side + $urandom_range(1, 3);
          end
        end
        if ($urandom_range(0, 2) == 0) begin
          if (side >= 2) begin
            row_len[$urandom_range(1, side - 1)] = $urandom_range(33, 36);
          end else begin
            row_len.insert(row_len.size(), int'($urandom_range(33, 36)));
          end
        end
      end
      6: begin
        repeat (side) row_len.insert(row_len.size(), side);
        nrows = (side <= 2 && $urandom_range(0, 2) == 0) ? 34 : side + $urandom_range(1, 3);
        while (row_len.size() < nrows) begin
          row_len.insert(row_len.size(), int'($urandom_range(0, side + 1)));
        end
      end
      7: begin
        row_len.insert(row_len.size(), side);
        nrows = $urandom_range(1, side);
        for (int r = 1; r < nrows; r++) begin
          row_len.insert(row_len.size(), int'($urandom_range(0, side)));
        end
      end
      8: begin
        row_len.insert(row_len.size(), 0);
        repeat ($urandom_range(0, 2)) row_len.insert(row_len.size(), int'($urandom_range(0, 4)));
      end
      9: ;
      default: repeat (side) row_len.insert(row_len.size(), side);
    endcase
    if (flavor < 8) begin
      fix_rows(side);
    end
    load_text($urandom_range(0, 1));
    read_out((flavor >= 8) ? 0 : side, $urandom_range(0, 3) == 0);
  endtask

  initial begin : stimulus
    int base, phase;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(FUNC_FETCH, 8'hA5);
    send_item(FUNC_LOAD, CH_NL);
    send_item(FUNC_FETCH, 8'h5A);
    empties += 2;
    grids_done += 2;

    write_mode(MODE_ROTATE);
    fixed_chars = '{8'hFF};
    row_len = '{1};
    load_text(1'b0);
    read_out(1, 1'b0);

    // A mode change in the middle of a combined line continues in the new mode.
    write_mode(MODE_COMBINED);
    fixed_chars = '{8'h00, 8'hFF, CH_BAR, 8'h80};
    row_len = '{2, 2};
    load_text(1'b1);
    fetch_n(7, 1'b0);
    write_mode(MODE_SPARE);
    fetch_n(4, 1'b0);
    grids_done++;

    base  = loads_sent + fetches_sent - ignored_loads;
    phase = 0;
    while (loads_sent + fetches_sent - ignored_loads - base < RANDOM_ITEMS) begin
      if (phase > 0 && $urandom_range(0, 3) == 0) begin
        write_mode(2'($urandom_range(0, 3)));
      end
      gaps_on = ($urandom_range(0, 2) != 0);
      // The first grid is sent while the receiver holds off, so the input backs up.
      if (phase == 0) begin
        hold_count <= hold_count + 1;
        wait (holding);
      end
      make_grid(phase == 0);
      if (phase == 0) begin
        settle();
      end
      phase++;
    end

    // Only the first lines of the widest grid are read back, to keep the run short.
    gaps_on = 1'b1;
    row_len.delete();
    row_len.insert(row_len.size(), 33);
    repeat (31) row_len.insert(row_len.size(), 32);
    load_text(1'b1);
    grids_done++;
    fetch_n(WIDE_FETCHES, 1'b0);

    settle();
    repeat (10) @(posedge clk);
    $display("Covered %0d grids (%0d empty) with %0d loads, %0d fetches and %0d mode writes.",
             grids_done, empties, loads_sent, fetches_sent, mode_writes);
    $display("Checked %0d output bytes, including the start of a 32-wide truncated grid.",
             bytes_checked);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
